// ----- design/assert_macros.svh -----
// assertion helpers included by ubr_ctl and the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked at every clock edge outside reset
`define UBR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property checked at every clock edge, reset included
`define UBR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UBR_ASSERT(lbl, clk, rstn, prop, msg)
`define UBR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/ubr_pkg.sv -----
package ubr_pkg;

    localparam int D_W    = 24;
    localparam int CNT_W  = 15;
    localparam int SENS_W = 3;
    localparam int TRIG_W = 10;
    localparam int SCL_W  = 8;
    localparam int OFS_W  = 16;
    localparam int CFG_W  = 16;

    typedef enum logic [1:0] {
        CFG_TRIGGER_US    = 2'd0,
        CFG_ECHO_LIMIT_US = 2'd1,
        CFG_SCALE         = 2'd2,
        CFG_OFFSET        = 2'd3
    } t_cfg_idx;

    localparam logic [TRIG_W-1:0] TRIGGER_US_RST = 10'd15;
    localparam logic [CNT_W-1:0]  ECHO_LIMIT_RST = 15'd20000;
    localparam logic [SCL_W-1:0]  SCALE_RST      = 8'd17;
    localparam logic [OFS_W-1:0]  OFFSET_RST     = 16'd3000;

    typedef struct packed {
        logic [TRIG_W-1:0] trigger_us;
        logic [CNT_W-1:0]  echo_limit_us;
        logic [SCL_W-1:0]  scale;
        logic [OFS_W-1:0]  offset;
    } t_cfg;

    // per-tick record that travels down the pipeline
    typedef struct packed {
        logic              trigger;
        logic [SENS_W-1:0] sensor;
        logic              busy;
        logic              done;
        logic              timed_out;
        logic              fin;
        logic [CNT_W-1:0]  width;
    } t_tick;

endpackage

// ----- design/ubr_ctl.sv -----
`include "assert_macros.svh"

module ubr_ctl
    import ubr_pkg::*;
#(
    parameter int SAMPLES = 3,
    parameter int SENSORS = 7,
    parameter int IDX_W   = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_acc,
    input  logic              i_start_req,
    input  logic [SENS_W-1:0] i_sensor,
    input  logic              i_echo,
    input  t_cfg              i_cfg,
    output logic              o_vld,
    output t_tick             o_rec,
    output logic [IDX_W-1:0]  o_idx
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SENS_W-1:0]  r_sensor, n_sensor;
    logic               r_tmo, n_tmo;

    logic               r_vld;
    t_tick              r_rec, n_rec;
    logic [IDX_W-1:0]   r_rec_idx;

    logic [CNT_W-1:0]   w_cnt1;
    logic               w_fin;
    logic               w_done;
    logic [CNT_W-1:0]   w_width;

    assign w_cnt1 = r_cnt + 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_sensor = r_sensor;
        n_tmo    = r_tmo;
        w_fin    = 1'b0;
        w_done   = 1'b0;
        w_width  = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req && (int'(i_sensor) < SENSORS)) begin
                    n_sensor = i_sensor;
                    n_phase  = PH_TRIG;
                    n_cnt    = '0;
                    n_idx    = '0;
                    n_tmo    = 1'b0;
                end
            end
            PH_TRIG: begin
                if (w_cnt1 >= CNT_W'(i_cfg.trigger_us)) begin
                    n_phase = PH_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = w_cnt1;
                end
            end
            PH_WAIT, PH_MEAS: begin
                if (i_echo && (r_phase == PH_WAIT)) begin
                    n_phase = PH_MEAS;
                    n_cnt   = '0;
                end else if (i_echo || (r_phase == PH_WAIT)) begin
                    // still waiting for the rise, or echo still high
                    if (w_cnt1 >= i_cfg.echo_limit_us) begin
                        n_tmo   = 1'b1;
                        w_fin   = 1'b1;
                        w_width = i_cfg.echo_limit_us;
                    end else begin
                        n_cnt = w_cnt1;
                    end
                end else begin
                    w_fin   = 1'b1;
                    w_width = r_cnt;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (w_fin) begin
            n_cnt = '0;
            if (r_idx == IDX_W'(SAMPLES - 1)) begin
                w_done  = 1'b1;
                n_phase = PH_IDLE;
                n_idx   = '0;
            end else begin
                n_phase = PH_TRIG;
                n_idx   = r_idx + 1'b1;
            end
        end

        n_rec.trigger   = (n_phase == PH_TRIG);
        n_rec.sensor    = n_sensor;
        n_rec.busy      = (n_phase != PH_IDLE);
        n_rec.done      = w_done;
        n_rec.timed_out = n_tmo;
        n_rec.fin       = w_fin;
        n_rec.width     = w_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_sensor <= '0;
            r_tmo    <= 1'b0;
        end else if (i_acc) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_sensor <= n_sensor;
            r_tmo    <= n_tmo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec     <= n_rec;
            r_rec_idx <= r_idx;
        end
    end

    assign o_vld = r_vld;
    assign o_rec = r_rec;
    assign o_idx = r_rec_idx;

    `UBR_ASSERT(a_idx_range, i_clk, i_rst_n, r_idx <= IDX_W'(SAMPLES - 1), "sample index out of range")
    `UBR_ASSERT(a_done_ends_sample, i_clk, i_rst_n, (r_vld && r_rec.done) |-> (r_rec.fin && r_rec_idx == IDX_W'(SAMPLES - 1)), "run ended off the last sample")
    `UBR_ASSERT(a_done_goes_idle, i_clk, i_rst_n, (r_vld && r_rec.done) |-> (!r_rec.busy && !r_rec.trigger), "run ended while still busy")

endmodule

// ----- design/ubr_dist.sv -----
module ubr_dist
    import ubr_pkg::*;
#(
    parameter int IDX_W = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  t_tick                 i_rec,
    input  logic [IDX_W-1:0]      i_idx,
    input  t_cfg                  i_cfg,
    output logic                  o_vld,
    output t_tick                 o_rec,
    output logic [IDX_W-1:0]      o_idx,
    output logic signed [D_W-1:0] o_d
);

    localparam int PROD_W = CNT_W + SCL_W;

    logic [PROD_W-1:0]     w_prod;
    logic signed [D_W-1:0] w_d;

    logic                  r_vld;
    t_tick                 r_rec;
    logic [IDX_W-1:0]      r_idx;
    logic signed [D_W-1:0] r_d;

    // width * scale - offset, always fits 24 bits signed
    assign w_prod = PROD_W'(i_rec.width) * PROD_W'(i_cfg.scale);
    assign w_d    = signed'(D_W'(w_prod)) - signed'(D_W'(i_cfg.offset));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rec <= i_rec;
            r_idx <= i_idx;
            r_d   <= w_d;
        end
    end

    assign o_vld = r_vld;
    assign o_rec = r_rec;
    assign o_idx = r_idx;
    assign o_d   = r_d;

endmodule

// ----- design/ubr_pick.sv -----
module ubr_pick
    import ubr_pkg::*;
#(
    parameter int SAMPLES = 3,
    parameter int IDX_W   = 2
) (
    input  logic                  i_clk,
    input  logic                  i_adv,
    input  logic                  i_vld,
    input  logic                  i_fin,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic signed [D_W-1:0] i_d,
    output logic signed [D_W-1:0] o_best
);

    localparam int SUM_W = D_W + $clog2(SAMPLES) + 1;
    localparam int ERR_W = SUM_W + $clog2(SAMPLES) + 1;
    localparam logic signed [ERR_W-1:0] N_SAMPLES = ERR_W'(SAMPLES);

    logic signed [D_W-1:0]   r_store [SAMPLES];
    logic signed [D_W-1:0]   w_val   [SAMPLES];
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] r_sum;

    logic signed [ERR_W-1:0] w_err  [SAMPLES];
    logic [ERR_W-1:0]        w_abs  [SAMPLES];
    logic [ERR_W-1:0]        w_best_err;
    logic signed [D_W-1:0]   w_best;

    // sum sees the sample being written this cycle
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < SAMPLES; k++) begin
            w_val[k] = (i_vld && i_fin && i_idx == IDX_W'(k)) ? i_d : r_store[k];
            w_sum    = w_sum + SUM_W'(w_val[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= w_sum;
            if (i_vld && i_fin) begin
                r_store[i_idx] <= i_d;
            end
        end
    end

    // closest to the mean: smallest |N*a - sum|, lowest index wins ties
    always_comb begin
        w_best_err = '0;
        w_best     = r_store[0];
        for (int k = 0; k < SAMPLES; k++) begin
            w_err[k] = N_SAMPLES * ERR_W'(r_store[k]) - ERR_W'(r_sum);
            w_abs[k] = (w_err[k] < 0) ? ERR_W'(-w_err[k]) : ERR_W'(w_err[k]);
            if (k == 0 || w_abs[k] < w_best_err) begin
                w_best_err = w_abs[k];
                w_best     = r_store[k];
            end
        end
    end

    assign o_best = w_best;

endmodule

// ----- design/ultrasonic_range_best_of_three.sv -----
// Ultrasonic ranging controller with best-of-SAMPLES selection. Each input item is one
// microsecond tick (start request, sensor index, echo level) and gives exactly one result
// item that shows the trigger level, latched sensor, busy, done, timeout flag and the last
// selected distance (width*scale - offset, 0.01 mm, closest sample to the mean). One item
// is taken every cycle while the pipeline is not held; a result passes four registers
// after the edge that accepts its item: control register, scaling multiplier, sample store
// with sum, then the selection into the output register. The whole pipeline holds while a
// result waits, so input ready follows output ready whenever the output register is full.
// Configuration writes are always ready and must only be made while no ticks are in flight.
`include "assert_macros.svh"

module ultrasonic_range_best_of_three
    import ubr_pkg::*;
#(
    parameter int SAMPLES = 3,
    parameter int SENSORS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_start_req,
    input  logic [SENS_W-1:0]     i_sensor,
    input  logic                  i_echo,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_trigger,
    output logic [SENS_W-1:0]     o_active_sensor,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic                  o_timed_out,
    output logic signed [D_W-1:0] o_distance
);

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    t_cfg                  r_cfg;
    logic                  w_adv;
    logic                  w_acc;

    logic                  w_s1_vld;
    t_tick                 w_s1_rec;
    logic [IDX_W-1:0]      w_s1_idx;

    logic                  w_s2_vld;
    t_tick                 w_s2_rec;
    logic [IDX_W-1:0]      w_s2_idx;
    logic signed [D_W-1:0] w_s2_d;

    logic                  r_s3_vld;
    t_tick                 r_s3_rec;
    logic signed [D_W-1:0] w_best;

    logic                  r_o_vld;
    t_tick                 r_o_rec;
    logic signed [D_W-1:0] r_o_dist;
    logic signed [D_W-1:0] r_last;

    assign w_adv       = !r_o_vld || i_out_ready;
    assign w_acc       = i_in_valid && w_adv;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_us    <= TRIGGER_US_RST;
            r_cfg.echo_limit_us <= ECHO_LIMIT_RST;
            r_cfg.scale         <= SCALE_RST;
            r_cfg.offset        <= OFFSET_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TRIGGER_US:    r_cfg.trigger_us    <= i_cfg_data[TRIG_W-1:0];
                CFG_ECHO_LIMIT_US: r_cfg.echo_limit_us <= i_cfg_data[CNT_W-1:0];
                CFG_SCALE:         r_cfg.scale         <= i_cfg_data[SCL_W-1:0];
                CFG_OFFSET:        r_cfg.offset        <= i_cfg_data[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ubr_ctl #(
        .SAMPLES (SAMPLES),
        .SENSORS (SENSORS),
        .IDX_W   (IDX_W)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_acc       (w_acc),
        .i_start_req (i_start_req),
        .i_sensor    (i_sensor),
        .i_echo      (i_echo),
        .i_cfg       (r_cfg),
        .o_vld       (w_s1_vld),
        .o_rec       (w_s1_rec),
        .o_idx       (w_s1_idx)
    );

    ubr_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_s1_vld),
        .i_rec   (w_s1_rec),
        .i_idx   (w_s1_idx),
        .i_cfg   (r_cfg),
        .o_vld   (w_s2_vld),
        .o_rec   (w_s2_rec),
        .o_idx   (w_s2_idx),
        .o_d     (w_s2_d)
    );

    ubr_pick #(
        .SAMPLES (SAMPLES),
        .IDX_W   (IDX_W)
    ) u_pick (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_vld  (w_s2_vld),
        .i_fin  (w_s2_rec.fin),
        .i_idx  (w_s2_idx),
        .i_d    (w_s2_d),
        .o_best (w_best)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_last   <= '0;
        end else if (w_adv) begin
            r_s3_vld <= w_s2_vld;
            r_o_vld  <= r_s3_vld;
            if (r_s3_vld && r_s3_rec.done) begin
                r_last <= w_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_rec <= w_s2_rec;
            r_o_rec  <= r_s3_rec;
            r_o_dist <= (r_s3_vld && r_s3_rec.done) ? w_best : r_last;
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_trigger       = r_o_rec.trigger;
    assign o_active_sensor = r_o_rec.sensor;
    assign o_busy_res      = r_o_rec.busy;
    assign o_done_res      = r_o_rec.done;
    assign o_timed_out     = r_o_rec.timed_out;
    assign o_distance      = r_o_dist;

    `UBR_ASSERT(a_done_not_busy, i_clk, i_rst_n,
        (r_o_vld && r_o_rec.done) |-> !r_o_rec.busy, "done item reports busy")
    `UBR_ASSERT(a_last_follows_done, i_clk, i_rst_n,
        (w_adv && r_s3_vld && r_s3_rec.done) |=> (r_last == r_o_dist),
        "held distance differs from reported one")
    `UBR_ASSERT(a_ready_tracks_out, i_clk, i_rst_n,
        (r_o_vld && !i_out_ready) |-> !o_in_ready, "item taken while pipeline held")

endmodule

// ----- verif/range_checker.sv -----
`timescale 1ns / 1ps

module range_checker
    import ubr_pkg::*;
#(
    parameter int SAMPLES = 3,
    parameter int SENSORS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,

    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_start_req,
    input  logic [SENS_W-1:0]     i_sensor,
    input  logic                  i_echo,

    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_trigger,
    input  logic [SENS_W-1:0]     i_active_sensor,
    input  logic                  i_busy_res,
    input  logic                  i_done_res,
    input  logic                  i_timed_out,
    input  logic signed [D_W-1:0] i_distance,

    output int                    o_errors,
    output int                    o_pending
);

    typedef enum logic [1:0] {
        RANGE_IDLE,
        RANGE_TRIGGER,
        RANGE_WAIT_ECHO,
        RANGE_MEASURE
    } t_range_phase;

    typedef struct {
        logic                  trigger;
        logic [SENS_W-1:0]     sensor;
        logic                  busy;
        logic                  done;
        logic                  timed_out;
        logic signed [D_W-1:0] distance;
    } t_tick_result;

    t_tick_result          expected_ticks[$];
    t_cfg                  regs;
    t_range_phase          phase;
    logic [CNT_W-1:0]      tick_cnt;
    int                    sample_no;
    int                    samples [SAMPLES];
    logic [SENS_W-1:0]     latched_sensor;
    logic                  timeout_seen;
    logic signed [D_W-1:0] last_distance;
    int                    errors = 0;
    int                    in_count = 0;
    int                    out_count = 0;

    assign o_pending = in_count - out_count;

    function automatic void reset_ranging();
        regs           = '{TRIGGER_US_RST, ECHO_LIMIT_RST, SCALE_RST, OFFSET_RST};
        phase          = RANGE_IDLE;
        tick_cnt       = '0;
        sample_no      = 0;
        latched_sensor = '0;
        timeout_seen   = 1'b0;
        last_distance  = '0;
        for (int k = 0; k < SAMPLES; k++) samples[k] = 0;
    endfunction

    // sample with the smallest |N*a_i - sum|, lowest index wins a tie
    function automatic logic signed [D_W-1:0] closest_to_mean();
        longint sum;
        longint err;
        longint best_err;
        int     best;
        sum = 0;
        best_err = 0;
        best = 0;
        for (int k = 0; k < SAMPLES; k++) sum += samples[k];
        for (int k = 0; k < SAMPLES; k++) begin
            err = longint'(SAMPLES) * samples[k] - sum;
            if (err < 0) err = -err;
            if (k == 0 || err < best_err) begin
                best_err = err;
                best = samples[k];
            end
        end
        return best[D_W-1:0];
    endfunction

    // returns 1 when this was the last sample of the run
    function automatic logic end_sample(logic [CNT_W-1:0] width);
        if (sample_no < SAMPLES)
            samples[sample_no] = int'(width) * int'(regs.scale) - int'(regs.offset);
        sample_no++;
        tick_cnt = '0;
        if (sample_no >= SAMPLES) begin
            last_distance = closest_to_mean();
            phase = RANGE_IDLE;
            sample_no = 0;
            return 1'b1;
        end
        phase = RANGE_TRIGGER;
        return 1'b0;
    endfunction

    function automatic t_tick_result range_tick(logic start, logic [SENS_W-1:0] sensor,
                                                logic echo);
        t_tick_result res;
        logic         done;
        done = 1'b0;
        case (phase)
            RANGE_IDLE: begin
                if (start && sensor < SENSORS) begin
                    latched_sensor = sensor;
                    phase = RANGE_TRIGGER;
                    tick_cnt = '0;
                    sample_no = 0;
                    timeout_seen = 1'b0;
                end
            end
            RANGE_TRIGGER: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= regs.trigger_us) begin
                    phase = RANGE_WAIT_ECHO;
                    tick_cnt = '0;
                end
            end
            RANGE_WAIT_ECHO: begin
                if (echo) begin
                    phase = RANGE_MEASURE;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= regs.echo_limit_us) begin
                        timeout_seen = 1'b1;
                        done = end_sample(regs.echo_limit_us);
                    end
                end
            end
            default: begin
                if (echo) begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= regs.echo_limit_us) begin
                        timeout_seen = 1'b1;
                        done = end_sample(regs.echo_limit_us);
                    end
                end else begin
                    done = end_sample(tick_cnt);
                end
            end
        endcase
        res.trigger   = (phase == RANGE_TRIGGER);
        res.sensor    = latched_sensor;
        res.busy      = (phase != RANGE_IDLE);
        res.done      = done;
        res.timed_out = timeout_seen;
        res.distance  = last_distance;
        return res;
    endfunction

    task automatic check_field(string name, longint want_v, longint got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            reset_ranging();
            expected_ticks.delete();
            in_count  <= 0;
            out_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TRIGGER_US:    regs.trigger_us    = i_cfg_data[TRIG_W-1:0];
                    CFG_ECHO_LIMIT_US: regs.echo_limit_us = i_cfg_data[CNT_W-1:0];
                    CFG_SCALE:         regs.scale         = i_cfg_data[SCL_W-1:0];
                    CFG_OFFSET:        regs.offset        = i_cfg_data[OFS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_ticks.push_back(range_tick(i_start_req, i_sensor, i_echo));
                in_count <= in_count + 1;
            end
            if (i_out_valid && i_out_ready) begin
                out_count <= out_count + 1;
                if (expected_ticks.size() == 0) begin
                    $error("result item with no tick waiting");
                    errors++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("trigger", want.trigger, i_trigger);
                    check_field("active_sensor", want.sensor, i_active_sensor);
                    check_field("busy_res", want.busy, i_busy_res);
                    check_field("done_res", want.done, i_done_res);
                    check_field("timed_out", want.timed_out, i_timed_out);
                    check_field("distance", longint'(want.distance), longint'(i_distance));
                end
            end
        end
        o_errors <= errors;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ubr_pkg::*;

    localparam int SAMPLES           = 3;
    localparam int SENSORS           = 7;
    localparam int RESET_CYCLES      = 9;
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int WATCHDOG_CYCLES   = 5000;
    localparam int ITEMS_PER_MODE    = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_start_req = 1'b0;
    logic [SENS_W-1:0]     i_sensor = '0;
    logic                  i_echo = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_trigger;
    logic [SENS_W-1:0]     o_active_sensor;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_timed_out;
    logic signed [D_W-1:0] o_distance;

    int                    fail_count;
    int                    results_pending;
    int                    sender_idle_pct = 0;
    int                    receiver_idle_pct = 0;
    logic                  stall_req = 1'b0;
    int                    quiet_cycles = 0;
    int                    ticks_sent = 0;
    // copies of the registers that shape the tick sequences
    logic [TRIG_W-1:0]     trig_len = TRIGGER_US_RST;
    logic [CNT_W-1:0]      echo_limit = ECHO_LIMIT_RST;

    ultrasonic_range_best_of_three #(
        .SAMPLES(SAMPLES),
        .SENSORS(SENSORS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_req    (i_start_req),
        .i_sensor       (i_sensor),
        .i_echo         (i_echo),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_trigger      (o_trigger),
        .o_active_sensor(o_active_sensor),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_timed_out    (o_timed_out),
        .o_distance     (o_distance)
    );

    range_checker #(
        .SAMPLES(SAMPLES),
        .SENSORS(SENSORS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_start_req    (i_start_req),
        .i_sensor       (i_sensor),
        .i_echo         (i_echo),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_trigger      (o_trigger),
        .i_active_sensor(o_active_sensor),
        .i_busy_res     (o_busy_res),
        .i_done_res     (o_done_res),
        .i_timed_out    (o_timed_out),
        .i_distance     (o_distance),
        .o_errors       (fail_count),
        .o_pending      (results_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req   <= 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic tick(logic start, logic [SENS_W-1:0] sensor, logic echo);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_start_req <= start;
        i_sensor    <= sensor;
        i_echo      <= echo;
        ticks_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // tick inside a run: start requests and sensor are noise here
    task automatic busy_tick(logic echo);
        tick($urandom_range(0, 3) == 0, SENS_W'($urandom_range(0, 7)), echo);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // unused upper data bits carry junk, the block must drop them
    task automatic set_regs(int trig, int lim, int scl, int ofs);
        drain_results();
        trig_len   = TRIG_W'(trig);
        echo_limit = CNT_W'(lim);
        write_reg(CFG_TRIGGER_US, {6'($urandom_range(0, 63)), trig_len});
        write_reg(CFG_ECHO_LIMIT_US, {1'($urandom_range(0, 1)), echo_limit});
        write_reg(CFG_SCALE, {8'($urandom_range(0, 255)), SCL_W'(scl)});
        write_reg(CFG_OFFSET, OFS_W'(ofs));
    endtask

    task automatic random_regs();
        int lim;
        int ofs;
        case ($urandom_range(0, 9))
            0:       lim = 0;
            1:       lim = 32767;
            2:       lim = $urandom_range(41, 32767);
            default: lim = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 5))
            0:       ofs = 0;
            1:       ofs = 65535;
            default: ofs = $urandom_range(0, 65535);
        endcase
        set_regs($urandom_range(0, 8), lim, $urandom_range(0, 255), ofs);
    endtask

    // rise wait of dly ticks, then an echo of wid ticks past the rising one;
    // either one reaching the limit ends the sample on a timeout
    task automatic echo_sample(int dly, int wid);
        int lim_eff;
        lim_eff = (echo_limit == 0) ? 1 : int'(echo_limit);
        if (dly >= lim_eff) begin
            repeat (lim_eff) busy_tick(1'b0);
        end else begin
            repeat (dly) busy_tick(1'b0);
            busy_tick(1'b1);
            if (wid >= lim_eff) begin
                repeat (lim_eff) busy_tick(1'b1);
            end else begin
                repeat (wid) busy_tick(1'b1);
                busy_tick(1'b0);
            end
        end
    endtask

    // one full run of three samples; a negative width is picked at random
    task automatic ranging_run(int w0, int w1, int w2);
        int wid;
        int dly;
        int lim_eff;
        int cap;
        tick(1'b1, SENS_W'($urandom_range(0, SENSORS - 1)), 1'($urandom_range(0, 1)));
        for (int s = 0; s < SAMPLES; s++) begin
            repeat ((trig_len == 0) ? 1 : trig_len) busy_tick(1'($urandom_range(0, 1)));
            lim_eff = (echo_limit == 0) ? 1 : int'(echo_limit);
            cap = (lim_eff - 1 < 60) ? lim_eff - 1 : 60;
            wid = (s == 0) ? w0 : (s == 1) ? w1 : w2;
            if (wid < 0)
                wid = (lim_eff <= 64 && $urandom_range(0, 9) == 0) ?
                      lim_eff : $urandom_range(0, cap);
            dly = (lim_eff <= 64 && $urandom_range(0, 9) == 0) ?
                  lim_eff : $urandom_range(0, (cap < 5) ? cap : 5);
            echo_sample(dly, wid);
        end
    endtask

    task automatic random_traffic(int item_goal);
        int goal;
        goal = ticks_sent + item_goal;
        while (ticks_sent < goal) begin
            case ($urandom_range(0, 19))
                0: random_regs();
                1, 2: begin
                    // idle noise that must not start a run
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(0, 1))
                            tick(1'b1, SENS_W'(SENSORS), 1'($urandom_range(0, 1)));
                        else
                            tick(1'b0, SENS_W'($urandom_range(0, 7)),
                                 1'($urandom_range(0, 1)));
                    end
                end
                default: ranging_run(-1, -1, -1);
            endcase
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct   = 11;
        receiver_idle_pct = 66;
        ranging_run(5, 12, 7);
        tick(1'b1, SENS_W'(SENSORS), 1'b1);
        tick(1'b0, 3'd3, 1'b1);
        set_regs(0, 1, 255, 0);
        ranging_run(0, 1, 0);
        set_regs(2, 0, 200, 100);
        ranging_run(0, 1, 0);
        set_regs(1, 50, 0, 65535);
        ranging_run(-1, -1, -1);
        set_regs(4, 60, 255, 0);
        ranging_run(49, 2, 40);

        random_traffic(ITEMS_PER_MODE / 2);
        stall_req <= 1'b1;
        random_traffic(ITEMS_PER_MODE / 2);
        drain_results();

        sender_idle_pct   = 66;
        receiver_idle_pct = 11;
        random_traffic(ITEMS_PER_MODE);
        drain_results();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        random_traffic(ITEMS_PER_MODE);
        // longer trigger, then echoes that time out at full scale
        set_regs(40, 10, 3, 7);
        ranging_run(-1, -1, -1);
        set_regs(5, 100, 255, 0);
        ranging_run(100, 100, 100);
        drain_results();

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
